>>> sv/xcfd_pkg.sv
// Shared constants and types for the XOR-checked frame deframer.
// No dependencies; the interfaces and the top level import this package.
package xcfd_pkg;

  localparam int unsigned PAYLOAD_BYTES_DEF = 4;
  localparam int unsigned WORD_BYTES        = 4;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned WORD_W            = WORD_BYTES * BYTE_W;
  localparam int unsigned APB_DATA_W        = 32;
  localparam int unsigned APB_ADDR_W        = 4;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_BYTE_RST     = 8'h01;
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST     = 8'h0D;

  // Register index, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TYPE_BYTE     = 2'd2,
    REG_TAIL_BYTE     = 2'd3
  } reg_idx_t;

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CHECK   = 6'b010000,
    PH_TAIL    = 6'b100000
  } phase_t;

endpackage

>>> sv/xcfd_rx_if.sv
// Byte channel into the deframer: valid/ready handshake plus one received byte.
// Depends on xcfd_pkg for the byte width.
interface xcfd_rx_if import xcfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/xcfd_word_if.sv
// Payload channel out of the deframer: valid/ready handshake plus one word.
// Depends on xcfd_pkg for the word width.
interface xcfd_word_if import xcfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] payload_word;

  modport source (output valid, output payload_word, input ready);
  modport sink   (input valid, input payload_word, output ready);
endinterface

>>> sv/xor_checked_frame_deframer.sv
// XOR-checked frame deframer, top level. Uses xcfd_pkg, xcfd_rx_if, xcfd_word_if.
// Frame format: header_first, header_second, type_byte, PAYLOAD_BYTES payload
// bytes, XOR checksum of the payload, tail_byte.
//
// The block takes one received byte per clock on rx while rx.ready is high and
// parses it at once: the phase register, the payload counter, the running XOR
// and the payload bytes are updated at the edge that accepts the byte. A
// finished frame is written, at the edge that accepts the tail byte, into the
// output register (word.valid), or into its skid entry while that is full. The
// sustained rate is one byte per clock; rx.ready drops only when both the
// output register and its skid entry hold words not yet taken. A header or
// type mismatch returns to the hunt (the offending byte is not retested as a
// first header), a checksum mismatch or a wrong tail drops the frame without
// a word. The payload word carries the first payload byte in bits 7:0; with
// fewer than four payload bytes the upper bytes are zero, with more only the
// first four are delivered while all of them enter the checksum. Registers
// (APB, byte address 4*index): 0 header_first, 1 header_second, 2 type_byte,
// 3 tail_byte; write them only while the block is idle.
module xor_checked_frame_deframer
  import xcfd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  xcfd_rx_if.sink               rx,
  xcfd_word_if.source           word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Bytes that reach the payload word, and counter width over a whole payload.
  localparam int unsigned EMIT_BYTES = (PAYLOAD_BYTES < WORD_BYTES) ? PAYLOAD_BYTES
                                                                    : WORD_BYTES;
  localparam int unsigned CNT_W      = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] header_first;
  logic [BYTE_W-1:0] header_second;
  logic [BYTE_W-1:0] type_byte;
  logic [BYTE_W-1:0] tail_byte;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      type_byte     <= TYPE_BYTE_RST;
      tail_byte     <= TAIL_BYTE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HEADER_FIRST:  header_first  <= pwdata[BYTE_W-1:0];
        REG_HEADER_SECOND: header_second <= pwdata[BYTE_W-1:0];
        REG_TYPE_BYTE:     type_byte     <= pwdata[BYTE_W-1:0];
        REG_TAIL_BYTE:     tail_byte     <= pwdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the register at the decoded index, zero-extended.
  always_comb begin
    case (reg_idx)
      REG_HEADER_FIRST:  prdata = APB_DATA_W'(header_first);
      REG_HEADER_SECOND: prdata = APB_DATA_W'(header_second);
      REG_TYPE_BYTE:     prdata = APB_DATA_W'(type_byte);
      REG_TAIL_BYTE:     prdata = APB_DATA_W'(tail_byte);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [BYTE_W-1:0] run_xor, run_xor_next;
  logic [BYTE_W-1:0] store [EMIT_BYTES];
  logic [WORD_W-1:0] packed_word;
  logic              skid_valid;
  logic              in_acc;
  logic              push;
  logic [BYTE_W-1:0] b;

  // Stall input only when both output slots are taken.
  assign rx.ready = !skid_valid;
  assign in_acc   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    run_xor_next = run_xor;
    push         = 1'b0;
    if (in_acc) begin
      case (phase)
        PH_HUNT:   phase_next = (b == header_first)  ? PH_SECOND : PH_HUNT;
        PH_SECOND: phase_next = (b == header_second) ? PH_TYPE   : PH_HUNT;
        PH_TYPE: begin
          if (b == type_byte) begin
            phase_next   = PH_PAYLOAD;
            cnt_next     = '0;
            run_xor_next = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          // Accumulate the checksum; advance to the check after the last byte.
          run_xor_next = run_xor ^ b;
          if (cnt == CNT_LAST) begin
            cnt_next   = '0;
            phase_next = PH_CHECK;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
        PH_CHECK: begin
          if (b == run_xor) begin
            phase_next = PH_TAIL;
          end else begin
            phase_next   = PH_HUNT;
            run_xor_next = '0;
          end
        end
        PH_TAIL: begin
          // Good tail delivers the word; a bad one drops the frame silently.
          run_xor_next = '0;
          phase_next   = PH_HUNT;
          push         = (b == tail_byte);
        end
        default: begin
          phase_next   = PH_HUNT;
          cnt_next     = '0;
          run_xor_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      cnt     <= '0;
      run_xor <= '0;
    end else begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      run_xor <= run_xor_next;
    end
  end

  // Payload bytes beyond the delivered word are only checksummed, not kept.
  always_ff @(posedge clk) begin
    for (int k = 0; k < EMIT_BYTES; k++) begin
      if (in_acc && phase == PH_PAYLOAD && cnt == CNT_W'(k)) begin
        store[k] <= b;
      end
    end
  end

  // First payload byte lands in the low byte; missing bytes read as zero.
  always_comb begin
    packed_word = '0;
    for (int k = 0; k < EMIT_BYTES; k++) begin
      packed_word[k*BYTE_W +: BYTE_W] = store[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] skid_word;
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic              pop;
  logic [WORD_W-1:0] new_word;

  assign pop  = out_valid && word.ready;
  // Bytes written this cycle are not yet in the store, so the tail byte never
  // overlaps a payload write: the packed store is already complete here.
  assign new_word = packed_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= skid_valid ? skid_word : new_word;
    end else if (push) begin
      if (!out_valid) begin
        out_word <= new_word;
      end else begin
        skid_word <= new_word;
      end
    end
  end

  assign word.valid        = out_valid;
  assign word.payload_word = out_word;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output register is empty");

  a_word_from_tail : assert property (@(posedge clk) disable iff (rst)
    $rose(word.valid) |-> $past(in_acc && phase == PH_TAIL))
    else $error("word appeared without an accepted tail byte");

  a_cnt_idle : assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PAYLOAD) |-> (cnt == '0))
    else $error("payload counter nonzero outside the payload phase");

  a_xor_clear_in_header : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_SECOND || phase == PH_TYPE) |-> (run_xor == '0))
    else $error("running checksum not cleared before a new frame");

endmodule

>>> test/xcfd_checker.sv
// Checker for the XOR-checked frame deframer: predicts payload words from accepted bytes
// and register writes, then compares them with the words that leave the block.
// Depends on xcfd_pkg, xcfd_rx_if and xcfd_word_if.
module xcfd_checker
  import xcfd_pkg::*;
#(
  parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  xcfd_rx_if                    rx,
  xcfd_word_if                  word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int unsigned           mismatches,
  output int unsigned           words_pending,
  output int unsigned           words_checked
);

  logic [BYTE_W-1:0] match_value [4];
  phase_t            frame_phase;
  int unsigned       payload_seen;
  logic [BYTE_W-1:0] frame_xor;
  logic [BYTE_W-1:0] payload_bytes [WORD_BYTES];
  logic [WORD_W-1:0] expected_words [$];
  logic [WORD_W-1:0] built_word;
  logic [WORD_W-1:0] oldest_word;
  int unsigned       fail_count;
  int unsigned       match_count;
  reg_idx_t          reg_sel;

  // Advance the frame parser by one byte; return 1 when a frame completes.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b);
    bit done;
    done = 1'b0;
    case (frame_phase)
      PH_HUNT: begin
        if (b == match_value[REG_HEADER_FIRST]) frame_phase = PH_SECOND;
      end
      PH_SECOND: begin
        frame_phase = (b == match_value[REG_HEADER_SECOND]) ? PH_TYPE : PH_HUNT;
      end
      PH_TYPE: begin
        if (b == match_value[REG_TYPE_BYTE]) begin
          frame_phase  = PH_PAYLOAD;
          payload_seen = 0;
          frame_xor    = '0;
        end else begin
          frame_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (payload_seen < WORD_BYTES) payload_bytes[payload_seen] = b;
        frame_xor ^= b;
        payload_seen++;
        if (payload_seen >= PAYLOAD_BYTES) begin
          payload_seen = 0;
          frame_phase  = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (b == frame_xor) begin
          frame_phase = PH_TAIL;
        end else begin
          frame_phase = PH_HUNT;
          frame_xor   = '0;
        end
      end
      PH_TAIL: begin
        frame_phase = PH_HUNT;
        frame_xor   = '0;
        if (b == match_value[REG_TAIL_BYTE]) begin
          // Bytes past the payload length stay zero.
          built_word = '0;
          for (int k = 0; k < WORD_BYTES && k < PAYLOAD_BYTES; k++)
            built_word[8*k +: 8] = payload_bytes[k];
          done = 1'b1;
        end
      end
      default: begin
        frame_phase  = PH_HUNT;
        payload_seen = 0;
        frame_xor    = '0;
      end
    endcase
    return done;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      match_value[REG_HEADER_FIRST]  = HEADER_FIRST_RST;
      match_value[REG_HEADER_SECOND] = HEADER_SECOND_RST;
      match_value[REG_TYPE_BYTE]     = TYPE_BYTE_RST;
      match_value[REG_TAIL_BYTE]     = TAIL_BYTE_RST;
      frame_phase  = PH_HUNT;
      payload_seen = 0;
      frame_xor    = '0;
      expected_words.delete();
      fail_count  = 0;
      match_count = 0;
    end else begin
      // Compare the outgoing word first: it can never stem from this edge's byte.
      if (word.valid && word.ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: payload_word expected none, actual %h", $time, word.payload_word);
        end else begin
          oldest_word = expected_words.pop_front();
          if (word.payload_word !== oldest_word) begin
            fail_count++;
            $display("%0t: payload_word expected %h, actual %h",
                     $time, oldest_word, word.payload_word);
          end else begin
            match_count++;
          end
        end
      end
      if (rx.valid && rx.ready) begin
        if (parse_byte(rx.rx_byte)) expected_words.push_back(built_word);
      end
      if (psel && penable && pready) begin
        reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
        if (pwrite) begin
          match_value[reg_sel] = pwdata[BYTE_W-1:0];
        end else if (prdata[BYTE_W-1:0] !== match_value[reg_sel]) begin
          fail_count++;
          $display("%0t: register %s readback expected %h, actual %h",
                   $time, reg_sel.name(), match_value[reg_sel], prdata[BYTE_W-1:0]);
        end
      end
    end
    mismatches    <= fail_count;
    words_pending <= expected_words.size();
    words_checked <= match_count;
  end

endmodule

>>> test/testbench.sv
// Top of the deframer testbench: clock, reset, byte stimulus, APB programming and
// payload-side stalls; the verdict comes from the checker's failure count.
// Depends on xcfd_pkg, the two channel interfaces, the deframer and xcfd_checker.
module testbench;
  import xcfd_pkg::*;

  localparam int unsigned FRAME_PAYLOAD = PAYLOAD_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned GAP_MAX       = 13;
  localparam int unsigned PHASE_BYTES   = 70;
  localparam int unsigned BURST_FRAMES  = 8;

  // Opening stream under reset settings:
  //   a good frame with all-ones and all-zeros payload bytes,
  //   a frame whose checksum is off by one bit,
  //   a repeated first header, where the second copy must not restart the hunt,
  //   a frame whose wrong tail equals the first header and must not be retested.
  localparam logic [BYTE_W-1:0] DIRECTED [30] = '{
    HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST,
    8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, TAIL_BYTE_RST,
    HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST,
    8'h12, 8'h34, 8'h56, 8'h78, 8'h09,
    HEADER_FIRST_RST, HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST,
    HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST,
    8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, HEADER_FIRST_RST
  };

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  xcfd_rx_if   rx ();
  xcfd_word_if word ();

  int unsigned mismatches;
  int unsigned words_pending;
  int unsigned words_checked;

  // Stimulus bookkeeping: the register values frames are built against,
  // how long each side may idle, and the one-off hold of the payload side.
  logic [BYTE_W-1:0] frame_cfg [4];
  int unsigned       bytes_sent    = 0;
  int unsigned       settings_used = 1;
  int unsigned       src_gap_max   = GAP_MAX;
  int unsigned       sink_gap_max  = GAP_MAX;
  int unsigned       sink_hold     = 0;
  int unsigned       cycle_count   = 0;

  xor_checked_frame_deframer #(
    .PAYLOAD_BYTES(FRAME_PAYLOAD)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .word    (word),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  xcfd_checker #(
    .PAYLOAD_BYTES(FRAME_PAYLOAD)
  ) frame_check (
    .clk           (clk),
    .rst           (rst),
    .rx            (rx),
    .word          (word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_checked (words_checked)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offer one byte word after a random idle gap, and hold it until taken.
  // Valid stays high on return so back-to-back words need no second assignment.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!(rx.valid && rx.ready));
    bytes_sent++;
  endtask

  // Build one frame against the current settings and send it. An intact frame
  // is well formed; otherwise pick noise, a bad second header or type, a bad
  // checksum or a bad tail, always with random payload content.
  task automatic send_frame(input bit intact);
    logic [BYTE_W-1:0] frame_q [$];
    logic [BYTE_W-1:0] pick;
    logic [BYTE_W-1:0] sum;
    int unsigned       kind;
    int unsigned       spot;
    int unsigned       n;
    kind = intact ? 0 : $urandom_range(1, 4);
    sum  = '0;
    if (kind == 1) begin
      n = $urandom_range(1, 6);
      repeat (n) frame_q.push_back(BYTE_W'($urandom));
    end else begin
      frame_q.push_back(frame_cfg[REG_HEADER_FIRST]);
      frame_q.push_back(frame_cfg[REG_HEADER_SECOND]);
      frame_q.push_back(frame_cfg[REG_TYPE_BYTE]);
      repeat (FRAME_PAYLOAD) begin
        pick = BYTE_W'($urandom);
        sum ^= pick;
        frame_q.push_back(pick);
      end
      frame_q.push_back(sum);
      frame_q.push_back(frame_cfg[REG_TAIL_BYTE]);
      case (kind)
        2:       spot = $urandom_range(1, 2);
        3:       spot = 3 + FRAME_PAYLOAD;
        4:       spot = 4 + FRAME_PAYLOAD;
        default: spot = frame_q.size();
      endcase
      // Flip at least one bit so the corrupted byte can never match.
      if (spot < frame_q.size()) frame_q[spot] ^= BYTE_W'($urandom_range(1, 255));
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  // Mostly well-formed frames, the rest noise and broken frames; switch the
  // sender between idling and full rate from frame to frame.
  task automatic send_random(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      send_frame($urandom_range(0, 9) < 6);
    end
  endtask

  // Drop valid, wait until every predicted word has been taken, then let the
  // parse pipeline settle so a frame dropped without a word is also done.
  task automatic wait_idle();
    rx.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, then an idle cycle so the
  // next transfer never reassigns psel in the same step.
  task automatic apb_access(input bit is_write, input reg_idx_t idx,
                            input logic [BYTE_W-1:0] value);
    logic [APB_DATA_W-1:0] bus_word;
    bus_word = $urandom;
    bus_word[BYTE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= bus_word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (is_write) frame_cfg[idx] = value;
    @(posedge clk);
  endtask

  // Write all four match registers while idle and read each one back.
  task automatic program_settings(input logic [BYTE_W-1:0] first, second, kind, tail);
    logic [BYTE_W-1:0] vals [4];
    vals = '{first, second, kind, tail};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      apb_access(1'b1, reg_idx_t'(i), vals[i]);
      apb_access(1'b0, reg_idx_t'(i), '0);
    end
    settings_used++;
  endtask

  // Payload side: idle a random number of cycles per word, now and then switch
  // between idling and taking every word at once, and honor a requested hold.
  initial begin
    int unsigned gap;
    word.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (sink_hold > 0) begin
        word.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      if ($urandom_range(0, 15) == 0) sink_gap_max = (sink_gap_max == 0) ? GAP_MAX : 0;
      gap = $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        word.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      word.ready <= 1'b1;
      do @(posedge clk); while (!(word.valid && word.ready));
    end
  end

  // Watchdog: end the run if it overruns the cycle budget.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    frame_cfg = '{HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST, TAIL_BYTE_RST};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the directed stream, then random frames.
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    send_random(PHASE_BYTES);

    // All-zero and all-ones match values.
    program_settings(8'h00, 8'h00, 8'h00, 8'h00);
    send_random(PHASE_BYTES);
    program_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_random(PHASE_BYTES);

    // Equal header bytes, so a repeated header is ambiguous to the hunt.
    program_settings(8'h3C, 8'h3C, BYTE_W'($urandom), BYTE_W'($urandom));
    send_random(PHASE_BYTES);

    // Random settings with the payload side held off for a long stretch while
    // good frames stream in at full rate: fill the output buffer and stall rx.
    program_settings(BYTE_W'($urandom), BYTE_W'($urandom),
                     BYTE_W'($urandom), BYTE_W'($urandom));
    sink_hold   = HOLD_CYCLES;
    src_gap_max = 0;
    repeat (BURST_FRAMES) send_frame(1'b1);
    send_random(PHASE_BYTES);

    // Back to the reset values through the bus.
    program_settings(HEADER_FIRST_RST, HEADER_SECOND_RST, TYPE_BYTE_RST, TAIL_BYTE_RST);
    send_random(PHASE_BYTES);

    wait_idle();
    $display("run covered %0d bytes across %0d match settings, %0d payload words matched,",
             bytes_sent, settings_used, words_checked);
    $display("with broken frames, noise, random idling and one long output hold");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
